// ===== design/bitmap_frame_allocator_core_assert.svh =====
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_core_assert.svh
// assertion helpers shared by the frame allocator modules
// ---------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// condition that must hold on every clock edge out of reset
`define BFA_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BFA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bfa_pkg.sv =====
// ---------------------------------------------------------------------------
// bfa_pkg
// shared constants, request codes and controller/datapath interface types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

    // default geometry
    localparam int BFA_FRAME_COUNT   = 32768;
    localparam int BFA_MAP_WORD_BITS = 32;

    // fixed field widths
    localparam int IDX_W   = 15;
    localparam int GRANT_W = 15;
    localparam int FREE_W  = 16;

    // request kinds
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } bfa_req_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_step;     // clear one summary word
        logic capture;      // latch an accepted request
        logic div_a;        // frame index -> map word
        logic div_b;        // bit in map word, map word -> summary word
        logic div_c;        // bit in summary word
        logic free_rd;      // read map and summary words for a free
        logic free_upd;     // write back a free
        logic sum_rd;       // read the summary word under the scan pointer
        logic scan_next;    // advance the scan pointer
        logic sum_pick;     // take lowest set bit of a non-empty summary word
        logic widx_calc;    // form map word index
        logic map_rd;       // read the chosen map word
        logic alloc_upd;    // set the lowest clear bit, update summary
        logic grant_calc;   // form the frame number, lower the count
        logic fail;         // nothing free
        logic resp_load;    // load the response register
    } bfa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;     // last summary word being cleared
        logic is_free;      // captured request is a free
        logic in_range;     // captured frame index is below the frame count
        logic scan_end;     // scan pointer past the last summary word
        logic sum_nonzero;  // summary word just read has a free map word
    } bfa_sts_t;

endpackage

`default_nettype wire

// ===== design/bfa_ctrl.sv =====
// ---------------------------------------------------------------------------
// bfa_ctrl
// request sequencer: clearing pass, free and allocate sequences, response
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_frame_allocator_core_assert.svh"

module bfa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    input  wire bfa_pkg::bfa_sts_t sts,
    output bfa_pkg::bfa_cmd_t     cmd
);
    import bfa_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_F_DIV1,
        S_F_DIV2,
        S_F_DIV3,
        S_F_UPD,
        S_A_RD,
        S_A_CHK,
        S_A_WIDX,
        S_A_MRD,
        S_A_UPD,
        S_A_GRANT,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_free)
                begin
                    state_next = sts.in_range ? S_F_DIV1 : S_RESP;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_F_DIV1:
            begin
                cmd.div_a  = 1'b1;
                state_next = S_F_DIV2;
            end
            S_F_DIV2:
            begin
                cmd.div_b  = 1'b1;
                state_next = S_F_DIV3;
            end
            S_F_DIV3:
            begin
                cmd.div_c   = 1'b1;
                cmd.free_rd = 1'b1;
                state_next  = S_F_UPD;
            end
            S_F_UPD:
            begin
                cmd.free_upd = 1'b1;
                state_next   = S_RESP;
            end
            S_A_RD:
            begin
                if (sts.scan_end)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.sum_rd = 1'b1;
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                if (sts.sum_nonzero)
                begin
                    cmd.sum_pick = 1'b1;
                    state_next   = S_A_WIDX;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_A_RD;
                end
            end
            S_A_WIDX:
            begin
                cmd.widx_calc = 1'b1;
                state_next    = S_A_MRD;
            end
            S_A_MRD:
            begin
                cmd.map_rd = 1'b1;
                state_next = S_A_UPD;
            end
            S_A_UPD:
            begin
                cmd.alloc_upd = 1'b1;
                state_next    = S_A_GRANT;
            end
            S_A_GRANT:
            begin
                cmd.grant_calc = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // response valid: set on load, dropped once taken
    always_comb
    begin
        if (cmd.resp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // checks
    `BFA_ASSERT_NEXT(a_load_shows, cmd.resp_load, rsp_valid, "loaded response not presented")
    `BFA_ASSERT_IMPL(a_no_overwrite, cmd.resp_load, !rsp_valid || rsp_ready, "pending response overwritten")
    `BFA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "second request taken while busy")

endmodule

`default_nettype wire

// ===== design/bfa_datapath.sv =====
// ---------------------------------------------------------------------------
// bfa_datapath
// frame bitmap, per-word summary bitmap, free count and response register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_frame_allocator_core_assert.svh"

module bfa_datapath #(
    parameter int FRAME_COUNT   = bfa_pkg::BFA_FRAME_COUNT,
    parameter int MAP_WORD_BITS = bfa_pkg::BFA_MAP_WORD_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_type,
    input  wire logic [bfa_pkg::IDX_W-1:0]   frame_index,
    input  wire bfa_pkg::bfa_cmd_t           cmd,
    output bfa_pkg::bfa_sts_t                sts,
    output logic [bfa_pkg::GRANT_W-1:0]      granted_frame,
    output logic                             alloc_failed,
    output logic [bfa_pkg::FREE_W-1:0]       free_frames
);
    import bfa_pkg::*;

    // geometry
    localparam int MAP_WORDS = (FRAME_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int SUM_WORDS = (MAP_WORDS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int SUM_PW    = $clog2(SUM_WORDS + 1);
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int CNT_W     = $clog2(FRAME_COUNT + 1);
    localparam int FRAME_W   = $clog2(MAP_WORDS * MAP_WORD_BITS);
    localparam int WIDX_W    = SUM_AW + BIT_W + 1;

    // reciprocal for division of a frame index by the word size
    localparam int DIV_SH  = IDX_W + BIT_W;
    localparam int RECIP   = ((1 << DIV_SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = IDX_W + RECIP_W;

    typedef logic [MAP_WORD_BITS-1:0] word_t;

    // lowest set bit position of a word
    function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
        word_t            iso;
        logic [BIT_W-1:0] pos;
        iso = w & (~w + word_t'(1));
        pos = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            if (iso[i])
            begin
                pos = pos | BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // storage
    word_t map_mem [MAP_WORDS];
    word_t sum_mem [SUM_WORDS];

    word_t               map_rd_reg;
    word_t               sum_rd_reg;
    logic                req_free_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [MAP_AW-1:0]   word_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic [SUM_AW-1:0]   sw_reg;
    logic [BIT_W-1:0]    sbit_reg;
    logic [SUM_PW-1:0]   scan_reg;
    logic [SUM_PW-1:0]   sum_lo_reg;
    logic [CNT_W-1:0]    free_total_reg;
    logic [SUM_AW-1:0]   clr_cnt_reg;
    logic [FRAME_W-1:0]  granted_reg;
    logic                failed_reg;
    logic [GRANT_W-1:0]  out_granted_reg;
    logic                out_failed_reg;
    logic [FREE_W-1:0]   out_free_reg;

    logic [PROD_W-1:0]   q1_prod;
    logic [PROD_W-1:0]   q2_prod;
    logic [MAP_AW-1:0]   q1_val;
    logic [SUM_AW-1:0]   q2_val;
    logic [BIT_W-1:0]    r1_val;
    logic [BIT_W-1:0]    r2_val;
    logic [MAP_AW-1:0]   widx_val;
    logic [FRAME_W-1:0]  grant_val;
    word_t               map_eff;
    word_t               map_new_free;
    word_t               map_new_alloc;
    word_t               sum_new_free;
    word_t               sum_new_full;
    logic                map_full;
    logic                map_we;
    word_t               map_wdata;
    logic                sum_we;
    logic [SUM_AW-1:0]   sum_waddr;
    word_t               sum_wdata;
    logic                sum_re;
    logic [SUM_AW-1:0]   sum_raddr;

    // divide frame index and map word index by the word size
    assign q1_prod = PROD_W'(idx_reg) * PROD_W'(RECIP);
    assign q1_val  = MAP_AW'(q1_prod >> DIV_SH);
    assign q2_prod = PROD_W'(IDX_W'(word_reg)) * PROD_W'(RECIP);
    assign q2_val  = SUM_AW'(q2_prod >> DIV_SH);
    assign r1_val  = BIT_W'(idx_reg - IDX_W'(IDX_W'(word_reg) * IDX_W'(MAP_WORD_BITS)));
    assign r2_val  = BIT_W'(IDX_W'(word_reg) - IDX_W'(IDX_W'(sw_reg) * IDX_W'(MAP_WORD_BITS)));

    // index arithmetic for the allocate path
    assign widx_val  = MAP_AW'(WIDX_W'(sw_reg) * WIDX_W'(MAP_WORD_BITS) + WIDX_W'(sbit_reg));
    assign grant_val = FRAME_W'(FRAME_W'(word_reg) * FRAME_W'(MAP_WORD_BITS)
                                + FRAME_W'(bit_reg));

    // a word whose summary bit is clear is full, whatever the memory holds
    assign map_eff       = sum_rd_reg[sbit_reg] ? map_rd_reg : '1;
    assign map_new_free  = map_eff & ~(word_t'(1) << bit_reg);
    assign sum_new_free  = sum_rd_reg | (word_t'(1) << sbit_reg);
    assign map_new_alloc = map_rd_reg | (map_rd_reg + word_t'(1));
    assign map_full      = &map_new_alloc;
    assign sum_new_full  = sum_rd_reg & ~(word_t'(1) << sbit_reg);

    // memory port selection
    assign map_we    = cmd.free_upd | cmd.alloc_upd;
    assign map_wdata = cmd.free_upd ? map_new_free : map_new_alloc;
    assign sum_re    = cmd.free_rd | cmd.sum_rd;
    assign sum_raddr = cmd.free_rd ? sw_reg : scan_reg[SUM_AW-1:0];

    always_comb
    begin
        sum_we    = 1'b0;
        sum_waddr = sw_reg;
        sum_wdata = sum_new_free;
        priority if (cmd.clr_step)
        begin
            sum_we    = 1'b1;
            sum_waddr = clr_cnt_reg;
            sum_wdata = '0;
        end
        else if (cmd.free_upd)
        begin
            sum_we = 1'b1;
        end
        else if (cmd.alloc_upd && map_full)
        begin
            sum_we    = 1'b1;
            sum_wdata = sum_new_full;
        end
    end

    // frame bitmap
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[word_reg] <= map_wdata;
        end
        if (cmd.free_rd || cmd.map_rd)
        begin
            map_rd_reg <= map_mem[word_reg];
        end
    end

    // summary bitmap, one bit per map word that still has a free frame
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re)
        begin
            sum_rd_reg <= sum_mem[sum_raddr];
        end
    end

    // persistent state: clear counter, scan hint, free count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            sum_lo_reg     <= SUM_PW'(SUM_WORDS);
            free_total_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SUM_AW'(1);
            end
            if (cmd.free_upd)
            begin
                if (SUM_PW'(sw_reg) < sum_lo_reg)
                begin
                    sum_lo_reg <= SUM_PW'(sw_reg);
                end
                if (free_total_reg < CNT_W'(FRAME_COUNT))
                begin
                    free_total_reg <= free_total_reg + CNT_W'(1);
                end
            end
            if (cmd.sum_pick || cmd.fail)
            begin
                sum_lo_reg <= scan_reg;
            end
            if (cmd.grant_calc && (free_total_reg != '0))
            begin
                free_total_reg <= free_total_reg - CNT_W'(1);
            end
        end
    end

    // working registers of one request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_free_reg <= (bfa_req_t'(req_type) == REQ_FREE);
            idx_reg      <= frame_index;
            scan_reg     <= sum_lo_reg;
            granted_reg  <= '0;
            failed_reg   <= 1'b0;
        end
        if (cmd.div_a)
        begin
            word_reg <= q1_val;
        end
        if (cmd.div_b)
        begin
            bit_reg <= r1_val;
            sw_reg  <= q2_val;
        end
        if (cmd.div_c)
        begin
            sbit_reg <= r2_val;
        end
        if (cmd.scan_next)
        begin
            scan_reg <= scan_reg + SUM_PW'(1);
        end
        if (cmd.sum_pick)
        begin
            sbit_reg <= lowest_set(sum_rd_reg);
            sw_reg   <= scan_reg[SUM_AW-1:0];
        end
        if (cmd.widx_calc)
        begin
            word_reg <= widx_val;
        end
        if (cmd.alloc_upd)
        begin
            bit_reg <= lowest_set(~map_rd_reg);
        end
        if (cmd.grant_calc)
        begin
            granted_reg <= grant_val;
        end
        if (cmd.fail)
        begin
            failed_reg <= 1'b1;
        end
        if (cmd.resp_load)
        begin
            out_granted_reg <= GRANT_W'(granted_reg);
            out_failed_reg  <= failed_reg;
            out_free_reg    <= FREE_W'(free_total_reg);
        end
    end

    // status
    assign sts.clr_last    = (clr_cnt_reg == SUM_AW'(SUM_WORDS - 1));
    assign sts.is_free     = req_free_reg;
    assign sts.in_range    = (32'(idx_reg) < 32'(FRAME_COUNT));
    assign sts.scan_end    = (scan_reg == SUM_PW'(SUM_WORDS));
    assign sts.sum_nonzero = |sum_rd_reg;

    assign granted_frame = out_granted_reg;
    assign alloc_failed  = out_failed_reg;
    assign free_frames   = out_free_reg;

    // checks
    `BFA_ASSERT_ALWAYS(a_count_cap, free_total_reg <= CNT_W'(FRAME_COUNT), "free count above frame total")
    `BFA_ASSERT_IMPL(a_word_open, cmd.alloc_upd, map_rd_reg != '1, "summary points at a full map word")
    `BFA_ASSERT_IMPL(a_pick_range, cmd.sum_pick, scan_reg < SUM_PW'(SUM_WORDS), "summary pick past the end")

endmodule

`default_nettype wire

// ===== design/bitmap_frame_allocator_core.sv =====
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_core
// first-fit page frame allocator over a frame bitmap
// ---------------------------------------------------------------------------
// One bit per frame (1 = allocated) is held in a map memory, with a summary
// memory carrying one bit per map word that still has a free frame, and a
// saturating free count. After reset every frame is allocated; a clearing
// pass over the SUM_WORDS summary words wipes the summary memory and holds
// req_ready low. A free request goes through decode, division steps DIV1 to
// DIV3 and a write-back before its response is loaded. An allocate scans
// the summary from the lowest word that may hold a free frame, reading and
// then checking one summary word at a time through the single read port of
// the summary memory, then forms the map word index, reads and updates the
// map word and forms the frame number; one that finds nothing free stops
// when the scan passes the last summary word. A finished response waits in
// an output register and the next request is taken while it is still
// pending. Frees of already free frames still count.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_frame_allocator_core #(
    parameter int FRAME_COUNT   = bfa_pkg::BFA_FRAME_COUNT,
    parameter int MAP_WORD_BITS = bfa_pkg::BFA_MAP_WORD_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire logic                       req_type,
    input  wire logic [bfa_pkg::IDX_W-1:0]  frame_index,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output logic [bfa_pkg::GRANT_W-1:0]     granted_frame,
    output logic                            alloc_failed,
    output logic [bfa_pkg::FREE_W-1:0]      free_frames
);
    import bfa_pkg::*;

    bfa_cmd_t cmd;
    bfa_sts_t sts;

    // request sequencer
    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // bitmaps, count and response register
    bfa_datapath #(
        .FRAME_COUNT   (FRAME_COUNT),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (req_type),
        .frame_index   (frame_index),
        .cmd           (cmd),
        .sts           (sts),
        .granted_frame (granted_frame),
        .alloc_failed  (alloc_failed),
        .free_frames   (free_frames)
    );

endmodule

`default_nettype wire
